>>> sv/rwz_pkg.sv
// shared constants, types and state codes of the rolling window z-score block
`default_nettype none
package rwz_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 24;
	localparam int ADDR_W      = $clog2(MAX_WINDOW);
	localparam int LEN_W       = 7;
	localparam int SEEN_W      = 7;
	localparam int MEAN_W      = 32;
	localparam int VAR_W       = 62;
	localparam int SD_W        = 32;
	localparam int Z_W         = 24;
	localparam int SUM_W       = 31;
	localparam int SQ_W        = 53;
	localparam int DIV_NW      = 75;
	localparam int DIV_DW      = 32;
	localparam int STEP_W      = 7;

	localparam logic [LEN_W-1:0]  WL_RESET    = 7'd20;
	localparam logic [LEN_W-1:0]  LEN_MIN     = 7'd2;
	localparam logic [LEN_W-1:0]  LEN_MAX     = 7'd64;
	localparam logic [SEEN_W-1:0] SEEN_MAX    = 7'd65;
	localparam logic [STEP_W-1:0] MEAN_STEPS  = 7'd38;
	localparam logic [STEP_W-1:0] VAR_STEPS   = 7'd75;
	localparam logic [STEP_W-1:0] Z_STEPS     = 7'd50;
	localparam logic [VAR_W-1:0]  VAR_MAX     = {VAR_W{1'b1}};
	localparam logic [VAR_W-1:0]  SQRT_BIT0   = 62'd1 << 60;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_MEAN_GO,
		S_MEAN_WAIT,
		S_VAR_GO,
		S_VAR_WAIT,
		S_SQRT,
		S_Z_GO,
		S_Z_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

>>> sv/rwz_if.sv
// channel interfaces: sample input, statistics result, window length write
`default_nettype none
interface rwz_sample_if;
	import rwz_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;
	modport source (output valid, sample, last_sample, input ready);
	modport sink (input valid, sample, last_sample, output ready);
endinterface

interface rwz_stat_if;
	import rwz_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     result_ready;
	logic signed [MEAN_W-1:0] window_mean;
	logic [VAR_W-1:0]         window_variance;
	logic [SD_W-1:0]          window_std_dev;
	logic signed [Z_W-1:0]    z_score;
	logic                     zero_spread;
	modport source (output valid, result_ready, window_mean, window_variance,
		window_std_dev, z_score, zero_spread, input ready);
	modport sink (input valid, result_ready, window_mean, window_variance,
		window_std_dev, z_score, zero_spread, output ready);
endinterface

interface rwz_cfg_if;
	import rwz_pkg::*;
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> sv/rwz_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module rwz_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/rwz_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module rwz_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rwz_pkg::div_req_t req,
	output rwz_pkg::div_rsp_t      rsp
);
	import rwz_pkg::*;

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] nq_q;
	logic [DIV_DW-1:0] den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW+1:0] diff;

	assign shifted = {rem_q, nq_q[DIV_NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			nq_q  <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!diff[DIV_DW+1]) begin
				rem_q <= diff[DIV_DW-1:0];
				nq_q  <= {nq_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_DW-1:0];
				nq_q  <= {nq_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = nq_q;
endmodule
`default_nettype wire

>>> sv/rolling_window_zscore.sv
// Rolling window z-score. Each accepted sample is stored in a 64-entry circular ram and
// then processed alone: the newest L stored samples are read one per cycle to form the
// window sum and sum of squares, then one shared restoring divider runs the mean and the
// variance, a bit-pair square root follows and the divider runs the z-score unless the
// square root is zero. Before more than L samples are seen the result is all zero with
// result_ready low and the whole computation is skipped. The result sits in an output
// register, so the next sample is taken while it waits. A sample marked last_sample
// clears the series state once its result is formed.
`default_nettype none
module rolling_window_zscore (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rwz_sample_if.sink  sample_ch,
	rwz_stat_if.source  stat_ch,
	rwz_cfg_if.sink     cfg
);
	import rwz_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0]             wl_q;
	logic [LEN_W-1:0]             len;
	logic                         in_xfer;
	logic [ADDR_W-1:0]            slot_q;
	logic [ADDR_W-1:0]            newest_q;
	logic [SEEN_W-1:0]            seen_q;
	logic [SEEN_W-1:0]            seen_next;
	logic [MAX_WINDOW-1:0]        vld_q;
	logic                         go_q;
	logic                         last_q;
	logic signed [SAMPLE_BITS-1:0] x_q;

	logic [LEN_W-1:0]              h_q;
	logic                          issue;
	logic [ADDR_W-1:0]             raddr;
	logic [SAMPLE_BITS-1:0]        rdata;
	logic                          iss_s1, vb_s1;
	logic                          iss_s2;
	logic signed [SAMPLE_BITS-1:0] val;
	logic [SAMPLE_BITS-1:0]        mag;
	logic signed [SAMPLE_BITS-1:0] val_s2;
	logic [2*SAMPLE_BITS-1:0]      sq_s2;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]               sumsq_q;

	logic [SUM_W-2:0]     smag;
	logic [37:0]          mean_num;
	logic [59:0]          prod_a_q, prod_b_q;
	logic [59:0]          dev;
	logic [13:0]          lenm;
	logic [MEAN_W-1:0]    mean_q;
	logic [VAR_W-1:0]     var_sat;
	logic [VAR_W-1:0]     var_q;
	logic [VAR_W-1:0]     sv_q, sr_q, sb_q;
	logic [VAR_W:0]       sq_t;
	logic                 sq_take;
	logic [VAR_W-1:0]     sr_next;
	logic [SD_W-1:0]      sd_q;
	logic signed [33:0]   znum_s;
	logic [32:0]          zmag;
	logic [49:0]          znum;
	logic                 zneg_q;
	logic [Z_W-1:0]       z_q;
	logic                 zs_q;
	logic [49:0]          zq;

	div_req_t req;
	div_rsp_t rsp;

	logic                     out_valid_q;
	logic                     rr_q;
	logic [MEAN_W-1:0]        om_q;
	logic [VAR_W-1:0]         ov_q;
	logic [SD_W-1:0]          os_q;
	logic [Z_W-1:0]           oz_q;
	logic                     ozs_q;
	logic                     out_load;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (wl_q < LEN_MIN) begin
			len = LEN_MIN;
		end else if (wl_q > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = wl_q;
		end
	end

	assign sample_ch.ready = (state_q == S_IDLE);
	assign in_xfer   = sample_ch.valid && sample_ch.ready;
	assign seen_next = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || stat_ch.ready);

	// window store walk, newest first
	assign issue = (state_q == S_ACC) && (h_q < len);
	assign raddr = newest_q - h_q[ADDR_W-1:0];

	rwz_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WINDOW)) u_store (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (slot_q),
		.wdata (sample_ch.sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign val = vb_s1 ? $signed(rdata) : '0;
	assign mag = val[SAMPLE_BITS-1] ? SAMPLE_BITS'(-val) : SAMPLE_BITS'(val);

	assign smag     = sum_q[SUM_W-1] ? (SUM_W-1)'(-sum_q) : (SUM_W-1)'(sum_q);
	assign mean_num = {smag, 8'b0} + 38'(len >> 1);
	assign dev      = prod_a_q - prod_b_q;
	assign lenm     = 14'(len) * 14'(len - 1'b1);
	assign var_sat  = (|rsp.quot[DIV_NW-1:VAR_W]) ? VAR_MAX : rsp.quot[VAR_W-1:0];

	assign sq_t    = {1'b0, sr_q} + {1'b0, sb_q};
	assign sq_take = {1'b0, sv_q} >= sq_t;
	assign sr_next = sq_take ? (sr_q >> 1) + sb_q : (sr_q >> 1);

	assign znum_s = $signed({{2{x_q[SAMPLE_BITS-1]}}, x_q, 8'b0})
		- $signed({{2{mean_q[MEAN_W-1]}}, mean_q});
	assign zmag   = znum_s[33] ? 33'(-znum_s) : 33'(znum_s);
	assign znum   = {1'b0, zmag, 16'b0} + 50'(sd_q >> 1);
	assign zq     = rsp.quot[49:0];

	always_comb begin
		req = '0;
		unique case (state_q)
			S_MEAN_GO: begin
				req.start = 1'b1;
				req.num   = {mean_num, 37'b0};
				req.den   = DIV_DW'(len);
				req.steps = MEAN_STEPS;
			end
			S_VAR_GO: begin
				req.start = 1'b1;
				req.num   = {dev[58:0], 16'(lenm >> 1)};
				req.den   = DIV_DW'(lenm);
				req.steps = VAR_STEPS;
			end
			S_Z_GO: begin
				req.start = 1'b1;
				req.num   = {znum, 25'b0};
				req.den   = sd_q;
				req.steps = Z_STEPS;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	rwz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_xfer) state_d = (seen_next > len) ? S_ACC : S_DONE;
			S_ACC:       if (h_q == len + 1'b1) state_d = S_MEAN_GO;
			S_MEAN_GO:   state_d = S_MEAN_WAIT;
			S_MEAN_WAIT: if (rsp.done) state_d = S_VAR_GO;
			S_VAR_GO:    state_d = S_VAR_WAIT;
			S_VAR_WAIT:  if (rsp.done) state_d = S_SQRT;
			S_SQRT:      if (sb_q == VAR_W'(1)) state_d = (sr_next == '0) ? S_DONE : S_Z_GO;
			S_Z_GO:      state_d = S_Z_WAIT;
			S_Z_WAIT:    if (rsp.done) state_d = S_DONE;
			S_DONE:      if (out_load) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wl_q        <= WL_RESET;
			slot_q      <= '0;
			seen_q      <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			iss_s1      <= 1'b0;
			iss_s2      <= 1'b0;
			h_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				wl_q <= cfg.data;
			end
			iss_s1 <= issue;
			iss_s2 <= iss_s1;
			h_q    <= (state_q == S_ACC) ? h_q + 1'b1 : '0;
			if (in_xfer) begin
				slot_q        <= slot_q + 1'b1;
				seen_q        <= seen_next;
				vld_q[slot_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					slot_q <= '0;
					seen_q <= '0;
					vld_q  <= '0;
				end
			end else if (stat_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q      <= sample_ch.sample;
			last_q   <= sample_ch.last_sample;
			newest_q <= slot_q;
			go_q     <= (seen_next > len);
			sum_q    <= '0;
			sumsq_q  <= '0;
			zs_q     <= 1'b0;
			z_q      <= '0;
		end
		vb_s1  <= vld_q[raddr];
		val_s2 <= val;
		sq_s2  <= mag * mag;
		if (iss_s2) begin
			sum_q   <= sum_q + SUM_W'(val_s2);
			sumsq_q <= sumsq_q + SQ_W'(sq_s2);
		end
		if (state_q == S_MEAN_GO) begin
			prod_a_q <= 60'(len) * 60'(sumsq_q);
			prod_b_q <= 60'(smag) * 60'(smag);
		end
		if (state_q == S_MEAN_WAIT && rsp.done) begin
			mean_q <= sum_q[SUM_W-1] ? MEAN_W'(-rsp.quot[MEAN_W-1:0]) : rsp.quot[MEAN_W-1:0];
		end
		if (state_q == S_VAR_WAIT && rsp.done) begin
			var_q <= var_sat;
			sv_q  <= var_sat;
			sr_q  <= '0;
			sb_q  <= SQRT_BIT0;
		end
		if (state_q == S_SQRT) begin
			if (sq_take) begin
				sv_q <= sv_q - sq_t[VAR_W-1:0];
			end
			sr_q <= sr_next;
			sb_q <= sb_q >> 2;
			if (sb_q == VAR_W'(1)) begin
				sd_q <= sr_next[SD_W-1:0];
				zs_q <= (sr_next == '0);
			end
		end
		if (state_q == S_Z_GO) begin
			zneg_q <= znum_s[33];
		end
		if (state_q == S_Z_WAIT && rsp.done) begin
			if (!zneg_q) begin
				z_q <= (zq > 50'h7FFFFF) ? 24'h7FFFFF : zq[Z_W-1:0];
			end else begin
				z_q <= (zq > 50'h800000) ? 24'h800000 : Z_W'(-zq[Z_W-1:0]);
			end
		end
		if (out_load) begin
			rr_q  <= go_q;
			om_q  <= go_q ? mean_q : '0;
			ov_q  <= go_q ? var_q : '0;
			os_q  <= go_q ? sd_q : '0;
			oz_q  <= go_q ? z_q : '0;
			ozs_q <= go_q && zs_q;
		end
	end

	assign stat_ch.valid           = out_valid_q;
	assign stat_ch.result_ready    = rr_q;
	assign stat_ch.window_mean     = om_q;
	assign stat_ch.window_variance = ov_q;
	assign stat_ch.window_std_dev  = os_q;
	assign stat_ch.z_score         = oz_q;
	assign stat_ch.zero_spread     = ozs_q;
endmodule
`default_nettype wire

>>> sv/rwz_checker.sv
// port-level checks of the rolling window z-score block and their bind
`default_nettype none
module rwz_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic                 result_ready,
	input wire logic [31:0]          window_mean,
	input wire logic [61:0]          window_variance,
	input wire logic [31:0]          window_std_dev,
	input wire logic [23:0]          z_score,
	input wire logic                 zero_spread
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_mean)
			&& $stable(z_score) && $stable(window_variance))
		else $error("result changed while stalled");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while one is in work");

	a_warmup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !result_ready |-> window_mean == '0 && window_variance == '0
			&& window_std_dev == '0 && z_score == '0 && !zero_spread)
		else $error("warm-up result not zero");

	a_spread_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_ready |-> zero_spread == (window_std_dev == '0))
		else $error("zero spread flag disagrees with std dev");

	a_spread_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_spread |-> z_score == '0 && result_ready)
		else $error("z-score not zero under zero spread");
endmodule

bind rolling_window_zscore rwz_checker u_rwz_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (sample_ch.valid),
	.in_ready        (sample_ch.ready),
	.out_valid       (stat_ch.valid),
	.out_ready       (stat_ch.ready),
	.result_ready    (stat_ch.result_ready),
	.window_mean     (stat_ch.window_mean),
	.window_variance (stat_ch.window_variance),
	.window_std_dev  (stat_ch.window_std_dev),
	.z_score         (stat_ch.z_score),
	.zero_spread     (stat_ch.zero_spread)
);
`default_nettype wire
